[hw/rtl/bankers_safety_allocator_core_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef BANKERS_SAFETY_ALLOCATOR_CORE_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle implication failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle implication failed.");

`endif

[hw/rtl/bsa_pkg.sv]
// Request and result types, opcodes and status codes of the allocator.
`default_nettype none
package bsa_pkg;

    localparam int WORK_W = 13;
    localparam int MAX_RES = 3;

    localparam logic [1:0] OP_LOAD_ROW   = 2'd0;
    localparam logic [1:0] OP_LOAD_AVAIL = 2'd1;
    localparam logic [1:0] OP_REQUEST    = 2'd2;
    localparam logic [1:0] OP_CHECK      = 2'd3;

    localparam logic [2:0] STAT_DONE     = 3'd0;
    localparam logic [2:0] STAT_GRANTED  = 3'd1;
    localparam logic [2:0] STAT_UNSAFE   = 3'd2;
    localparam logic [2:0] STAT_EXCEEDS  = 3'd3;
    localparam logic [2:0] STAT_SHORT    = 3'd4;
    localparam logic [2:0] STAT_BAD_PROC = 3'd5;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] process_id;
        logic [7:0] units_0;
        logic [7:0] units_1;
        logic [7:0] units_2;
        logic [7:0] held_0;
        logic [7:0] held_1;
        logic [7:0] held_2;
    } t_in_req;

    typedef struct packed {
        logic [2:0] status;
        logic       safe_flag;
    } t_out_res;

    function automatic logic [7:0] units_at(t_in_req q, int r);
        priority if (r == 0) begin
            return q.units_0;
        end else if (r == 1) begin
            return q.units_1;
        end else begin
            return q.units_2;
        end
    endfunction

    function automatic logic [7:0] held_at(t_in_req q, int r);
        priority if (r == 0) begin
            return q.held_0;
        end else if (r == 1) begin
            return q.held_1;
        end else begin
            return q.held_2;
        end
    endfunction

endpackage
`default_nettype wire

[hw/rtl/bankers_safety_allocator_core.sv]
// Banker's-algorithm allocator: row tables, request checks and iterative safety scan.
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_in_req  (t_in_req)
//  result    out        o_out_valid / i_out_stall  o_out_res (t_out_res)
//
// Loads and refused requests pass from acceptance through S_EXEC and S_FIN to the output register.
// A safety check or a passing request also runs the scan in S_SCAN, one row at a time, at most
// NUM_PROCESSES rounds of NUM_PROCESSES rows, before it reaches S_FIN.
// One shared row unit (need compare and work add) evaluates a single row each cycle.
// Synchronous reset clears all tables. A new request is taken only when the block is idle.
// A finished result waits in its own stage until the output register is free.
`default_nettype none
`include "bankers_safety_allocator_core_macros.svh"
module bankers_safety_allocator_core #(
    parameter int NUM_PROCESSES = 5,
    parameter int NUM_RESOURCES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bsa_pkg::t_in_req   i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bsa_pkg::t_out_res  o_out_res
);
    import bsa_pkg::*;

    localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
    localparam int FW = $clog2(NUM_PROCESSES + 1);
    localparam logic [PW-1:0] LAST_ROW = PW'(NUM_PROCESSES - 1);
    localparam logic [FW-1:0] ALL_ROWS = FW'(NUM_PROCESSES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    t_in_req                 r_req, n_req;
    t_out_res                r_res, n_res;
    t_out_res                r_out, n_out;
    logic                    r_out_valid, n_out_valid;
    logic [7:0]              r_avail [NUM_RESOURCES];
    logic [7:0]              n_avail [NUM_RESOURCES];
    logic [7:0]              r_max   [NUM_PROCESSES][NUM_RESOURCES];
    logic [7:0]              n_max   [NUM_PROCESSES][NUM_RESOURCES];
    logic [7:0]              r_alloc [NUM_PROCESSES][NUM_RESOURCES];
    logic [7:0]              n_alloc [NUM_PROCESSES][NUM_RESOURCES];
    logic [WORK_W-1:0]       r_work  [NUM_RESOURCES];
    logic [WORK_W-1:0]       n_work  [NUM_RESOURCES];
    logic [NUM_PROCESSES-1:0] r_done, n_done;
    logic [FW-1:0]           r_fin, n_fin;
    logic                    r_prog, n_prog;
    logic [PW-1:0]           r_ptr, n_ptr;
    logic                    r_tent, n_tent;

    logic                    pid_ok;
    logic [PW-1:0]           pid_idx;
    logic [PW-1:0]           rd_idx;
    logic [7:0]              req_units [NUM_RESOURCES];
    logic [7:0]              alloc_eff [NUM_RESOURCES];
    logic [8:0]              need      [NUM_RESOURCES];
    logic [NUM_RESOURCES-1:0] fits, over, short_of;
    logic                    row_fit;
    logic [FW-1:0]           fin_step;
    logic                    prog_step;
    logic                    scan_safe;

    assign pid_ok  = (int'(r_req.process_id) < NUM_PROCESSES);
    assign pid_idx = r_req.process_id[PW-1:0];
    assign rd_idx  = (r_state == S_SCAN) ? r_ptr : pid_idx;

    always_comb begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            req_units[r] = units_at(r_req, r);
            alloc_eff[r] = r_alloc[rd_idx][r]
                         + ((r_tent && (rd_idx == pid_idx)) ? req_units[r] : 8'd0);
            need[r]      = {1'b0, r_max[rd_idx][r]} - {1'b0, alloc_eff[r]};
            fits[r]      = need[r][8]
                         || ({{(WORK_W-8){1'b0}}, need[r][7:0]} <= r_work[r]);
            over[r]      = need[r][8] || (req_units[r] > need[r][7:0]);
            short_of[r]  = req_units[r] > r_avail[r];
        end
    end

    assign row_fit   = !r_done[r_ptr] && (&fits);
    assign fin_step  = r_fin + FW'(row_fit);
    assign prog_step = r_prog || row_fit;
    assign scan_safe = (fin_step == ALL_ROWS);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_avail     = r_avail;
        n_max       = r_max;
        n_alloc     = r_alloc;
        n_work      = r_work;
        n_done      = r_done;
        n_fin       = r_fin;
        n_prog      = r_prog;
        n_ptr       = r_ptr;
        n_tent      = r_tent;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_req;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '{status: STAT_DONE, safe_flag: 1'b0};
                n_state = S_FIN;
                n_done  = '0;
                n_fin   = '0;
                n_prog  = 1'b0;
                n_ptr   = '0;
                n_tent  = 1'b0;
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                    n_work[r] = {{(WORK_W-8){1'b0}}, r_avail[r]};
                end
                unique case (r_req.opcode)
                    OP_LOAD_ROW: begin
                        if (!pid_ok) begin
                            n_res.status = STAT_BAD_PROC;
                        end else begin
                            for (int r = 0; r < NUM_RESOURCES; r++) begin
                                n_max[pid_idx][r]   = units_at(r_req, r);
                                n_alloc[pid_idx][r] = held_at(r_req, r);
                            end
                        end
                    end
                    OP_LOAD_AVAIL: begin
                        for (int r = 0; r < NUM_RESOURCES; r++) begin
                            n_avail[r] = req_units[r];
                        end
                    end
                    OP_CHECK: begin
                        n_state = S_SCAN;
                    end
                    OP_REQUEST: begin
                        priority if (!pid_ok) begin
                            n_res.status = STAT_BAD_PROC;
                        end else if (|over) begin
                            n_res.status = STAT_EXCEEDS;
                        end else if (|short_of) begin
                            n_res.status = STAT_SHORT;
                        end else begin
                            n_tent  = 1'b1;
                            n_state = S_SCAN;
                            for (int r = 0; r < NUM_RESOURCES; r++) begin
                                n_work[r] = {{(WORK_W-8){1'b0}}, r_avail[r] - req_units[r]};
                            end
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SCAN: begin
                if (row_fit) begin
                    for (int r = 0; r < NUM_RESOURCES; r++) begin
                        n_work[r] = r_work[r] + {{(WORK_W-8){1'b0}}, alloc_eff[r]};
                    end
                    n_done[r_ptr] = 1'b1;
                end
                n_fin  = fin_step;
                n_prog = prog_step;
                if (r_ptr == LAST_ROW) begin
                    n_ptr  = '0;
                    n_prog = 1'b0;
                    if (scan_safe || !prog_step) begin
                        n_state = S_FIN;
                        n_tent  = 1'b0;
                        if (!r_tent) begin
                            n_res = '{status: STAT_DONE, safe_flag: scan_safe};
                        end else if (scan_safe) begin
                            n_res = '{status: STAT_GRANTED, safe_flag: 1'b1};
                            for (int r = 0; r < NUM_RESOURCES; r++) begin
                                n_avail[r]          = r_avail[r] - req_units[r];
                                n_alloc[pid_idx][r] = r_alloc[pid_idx][r] + req_units[r];
                            end
                        end else begin
                            n_res = '{status: STAT_UNSAFE, safe_flag: 1'b0};
                        end
                    end
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_done      <= '0;
            r_fin       <= '0;
            r_prog      <= 1'b0;
            r_ptr       <= '0;
            r_tent      <= 1'b0;
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                r_avail[r] <= 8'd0;
            end
            for (int p = 0; p < NUM_PROCESSES; p++) begin
                for (int r = 0; r < NUM_RESOURCES; r++) begin
                    r_max[p][r]   <= 8'd0;
                    r_alloc[p][r] <= 8'd0;
                end
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_done      <= n_done;
            r_fin       <= n_fin;
            r_prog      <= n_prog;
            r_ptr       <= n_ptr;
            r_tent      <= n_tent;
            r_avail     <= n_avail;
            r_max       <= n_max;
            r_alloc     <= n_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_out  <= n_out;
        r_work <= n_work;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    `ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_IMPLIES(a_grant_is_safe, o_out_valid && (o_out_res.status == STAT_GRANTED), o_out_res.safe_flag)
    `ASSERT_IMPLIES(a_scan_ptr_range, r_state == S_SCAN, r_ptr <= LAST_ROW)
    `ASSERT_IMPLIES(a_fin_bound, r_state == S_SCAN, r_fin <= ALL_ROWS)

endmodule
`default_nettype wire
